### rtl/bpds_pkg.sv
// Shared types and constants for the bearing PID differential steer block.
// Used by the channel interfaces and the top level; no dependencies.
package bpds_pkg;

  // field widths
  localparam int unsigned BoxW     = 10;
  localparam int unsigned VelW     = 11;
  localparam int unsigned CruiseW  = 11;
  localparam int unsigned LimitW   = 10;
  localparam int unsigned GainW    = 16;
  localparam int unsigned BearingW = 16;
  localparam int unsigned SumW     = 32;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCruise = 3'd0,
    CfgLimit  = 3'd1,
    CfgGainP  = 3'd2,
    CfgGainI  = 3'd3,
    CfgGainD  = 3'd4
  } cfg_idx_e;

  localparam logic [LimitW-1:0] LimitReset = 10'd600;

  // frame geometry
  localparam int unsigned FrameWidthDef = 316;
  localparam int unsigned OffW          = BoxW + 2;

  // tan(30.5 deg) in Q16, doubled for the Y start value
  localparam int unsigned TanHalfFovQ16 = 38604;
  localparam int unsigned YScaleW       = 17;
  localparam int unsigned YProdW        = (BoxW + 1) + YScaleW;

  // vectoring CORDIC
  localparam int unsigned CordicIters  = 16;
  localparam int unsigned CordicSteps  = 2;
  localparam int unsigned CordicStages = CordicIters / CordicSteps;
  localparam int unsigned IterW        = $clog2(CordicIters);
  localparam int unsigned CordicW      = 32;
  localparam int unsigned ZW           = 24;

  // atan(2^-i) in Q16 degrees
  localparam logic signed [ZW-1:0] AtanLut [CordicIters] = '{
    24'sd2949120, 24'sd1740967, 24'sd919879, 24'sd466945,
    24'sd234379,  24'sd117304,  24'sd58666,  24'sd29335,
    24'sd14668,   24'sd7334,    24'sd3667,   24'sd1833,
    24'sd917,     24'sd458,     24'sd229,    24'sd115
  };

  // 90 degrees in Q8.8, an upper bound on the bearing magnitude
  localparam int BearingBound = 23040;

endpackage

### rtl/bpds_in_if.sv
// Detection request channel: valid/ready handshake with the detection fields.
// Depends on bpds_pkg for field widths.
interface bpds_in_if;
  logic                         valid;
  logic                         ready;
  logic                         target_found;
  logic [bpds_pkg::BoxW-1:0]    box_left;
  logic [bpds_pkg::BoxW-1:0]    box_width;
  logic                         mode;

  modport source (
    output valid, target_found, box_left, box_width, mode,
    input  ready
  );

  modport sink (
    input  valid, target_found, box_left, box_width, mode,
    output ready
  );
endinterface

### rtl/bpds_out_if.sv
// Velocity result channel: valid/ready handshake with the wheel commands.
// Depends on bpds_pkg for field widths.
interface bpds_out_if;
  logic                               valid;
  logic                               ready;
  logic                               out_valid;
  logic signed [bpds_pkg::VelW-1:0]   left_velocity;
  logic signed [bpds_pkg::VelW-1:0]   right_velocity;

  modport source (
    output valid, out_valid, left_velocity, right_velocity,
    input  ready
  );

  modport sink (
    input  valid, out_valid, left_velocity, right_velocity,
    output ready
  );
endinterface

### rtl/bearing_pid_differential_steer.sv
// Top level of the bearing PID differential steer block.
// Depends on bpds_pkg, bpds_in_if and bpds_out_if.
//
// Usage:
//   in_i  carries one detection per request (target_found, box_left,
//         box_width, mode); out_o returns one velocity pair per request.
//   The configuration port writes cruise velocity, velocity limit and the
//   three PID gains by index; write only while no request is in flight.
// Timing:
//   Thirteen register stages: an input stage, eight CORDIC stages of two
//   iterations each, a bearing/integrator stage, a multiplier stage, a
//   rounding stage and the output register. One request is accepted per cycle
//   while the pipe does not stall.
//   The integrator and previous bearing update in the bearing stage, in
//   request order, so requests may follow each other in every cycle.
// Stalls:
//   Each stage holds while the one after it is full and blocked, so bubbles
//   close up and requests keep entering until the pipe is full.
// Reset:
//   Clears the stage valids, the PID state and the configuration (limit 600).
module bearing_pid_differential_steer #(
  parameter int unsigned FrameWidth = bpds_pkg::FrameWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bpds_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bpds_pkg::CfgDataW-1:0]   cfg_wdata_i,
  bpds_in_if.sink                         in_i,
  bpds_out_if.source                      out_o
);

  localparam int unsigned NC     = bpds_pkg::CordicStages;
  localparam int unsigned PIdx   = NC + 1;
  localparam int unsigned MIdx   = NC + 2;
  localparam int unsigned RIdx   = NC + 3;
  localparam int unsigned OIdx   = NC + 4;
  localparam int unsigned NS     = NC + 5;
  localparam int unsigned CW     = bpds_pkg::CordicW;
  localparam int unsigned ZW     = bpds_pkg::ZW;
  localparam int unsigned OffW   = bpds_pkg::OffW;
  localparam int unsigned BW     = bpds_pkg::BearingW;
  localparam int unsigned SW     = bpds_pkg::SumW;
  localparam int unsigned GW     = bpds_pkg::GainW;
  localparam int unsigned PW     = 48;
  localparam int unsigned VW     = 34;

  localparam logic [OffW-1:0]               HalfFrame = OffW'(FrameWidth / 2);
  localparam logic signed [CW-1:0]          X0        = CW'(FrameWidth * 65536);
  localparam logic [bpds_pkg::YScaleW-1:0]  YScale    =
    bpds_pkg::YScaleW'(2 * bpds_pkg::TanHalfFovQ16);

  // configuration
  logic signed [bpds_pkg::CruiseW-1:0] cruise_q;
  logic [bpds_pkg::LimitW-1:0]         limit_q;
  logic signed [GW-1:0]                gain_p_q, gain_i_q, gain_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cruise_q <= '0;
      limit_q  <= bpds_pkg::LimitReset;
      gain_p_q <= '0;
      gain_i_q <= '0;
      gain_d_q <= '0;
    end else if (cfg_we_i) begin
      case (bpds_pkg::cfg_idx_e'(cfg_idx_i))
        bpds_pkg::CfgCruise: cruise_q <= cfg_wdata_i[bpds_pkg::CruiseW-1:0];
        bpds_pkg::CfgLimit:  limit_q  <= cfg_wdata_i[bpds_pkg::LimitW-1:0];
        bpds_pkg::CfgGainP:  gain_p_q <= cfg_wdata_i[GW-1:0];
        bpds_pkg::CfgGainI:  gain_i_q <= cfg_wdata_i[GW-1:0];
        bpds_pkg::CfgGainD:  gain_d_q <= cfg_wdata_i[GW-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and the ready chain
  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = out_o.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_i.ready = rdy[0];

  // CORDIC lane: stage 0 holds the start vector, stage s after 2s iterations
  logic signed [CW-1:0] x_q [NC+1];
  logic signed [CW-1:0] y_q [NC+1];
  logic signed [ZW-1:0] z_q [NC+1];
  logic                 found_q [NC+1];
  logic                 mode_q  [NC+1];
  logic                 neg_q   [NC+1];
  logic                 zero_q  [NC+1];

  logic [OffW-1:0]             off_u;
  logic                        off_neg;
  logic [bpds_pkg::BoxW:0]     off_mag;
  logic [bpds_pkg::YProdW-1:0] y_prod;

  always_comb begin
    off_u   = OffW'(in_i.box_left) + OffW'(in_i.box_width >> 1) - HalfFrame;
    off_neg = off_u[OffW-1];
    off_mag = off_neg ? (bpds_pkg::BoxW+1)'(-off_u) : (bpds_pkg::BoxW+1)'(off_u);
    y_prod  = bpds_pkg::YProdW'(off_mag) * bpds_pkg::YProdW'(YScale);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      found_q[0] <= in_i.target_found;
      mode_q[0]  <= in_i.mode;
      neg_q[0]   <= off_neg;
      zero_q[0]  <= (off_mag == '0);
      x_q[0]     <= X0;
      y_q[0]     <= CW'(y_prod);
      z_q[0]     <= '0;
    end
  end

  for (genvar s = 0; s < NC; s++) begin : g_cordic
    logic signed [CW-1:0] x_d, y_d, x_n;
    logic signed [ZW-1:0] z_d;

    always_comb begin
      x_d = x_q[s];
      y_d = y_q[s];
      z_d = z_q[s];
      x_n = x_q[s];
      for (int j = 0; j < bpds_pkg::CordicSteps; j++) begin
        if (!y_d[CW-1] && (y_d != '0)) begin
          x_n = x_d + (y_d >>> (s * bpds_pkg::CordicSteps + j));
          y_d = y_d - (x_d >>> (s * bpds_pkg::CordicSteps + j));
          z_d = z_d + bpds_pkg::AtanLut[bpds_pkg::IterW'(s * bpds_pkg::CordicSteps + j)];
        end else begin
          x_n = x_d - (y_d >>> (s * bpds_pkg::CordicSteps + j));
          y_d = y_d + (x_d >>> (s * bpds_pkg::CordicSteps + j));
          z_d = z_d - bpds_pkg::AtanLut[bpds_pkg::IterW'(s * bpds_pkg::CordicSteps + j)];
        end
        x_d = x_n;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s+1]) begin
        x_q[s+1]     <= x_d;
        y_q[s+1]     <= y_d;
        z_q[s+1]     <= z_d;
        found_q[s+1] <= found_q[s];
        mode_q[s+1]  <= mode_q[s];
        neg_q[s+1]   <= neg_q[s];
        zero_q[s+1]  <= zero_q[s];
      end
    end
  end

  // bearing stage: round the angle, take the difference, update the integrator
  logic signed [BW-1:0] last_q;
  logic signed [SW-1:0] acc_q;
  logic signed [ZW-1:0] z_pos;
  logic [ZW-1:0]        z_rnd;
  logic signed [BW-1:0] b_d;
  logic signed [BW:0]   d_d;
  logic signed [SW:0]   s_wide;
  logic signed [SW-1:0] s_d;
  logic                 state_we;

  always_comb begin
    z_pos  = z_q[NC][ZW-1] ? '0 : z_q[NC];
    z_rnd  = (ZW'(z_pos) + ZW'(128)) >> 8;
    if (zero_q[NC]) begin
      b_d = '0;
    end else if (neg_q[NC]) begin
      b_d = -BW'(z_rnd);
    end else begin
      b_d = BW'(z_rnd);
    end
    d_d    = (BW+1)'(b_d) - (BW+1)'(last_q);
    s_wide = (SW+1)'(acc_q) + (SW+1)'(b_d);
    if (s_wide[SW] != s_wide[SW-1]) begin
      // saturate towards the sign of the true sum
      s_d = s_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      s_d = s_wide[SW-1:0];
    end
    state_we = rdy[PIdx] && v_q[NC] && found_q[NC];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      acc_q  <= '0;
    end else if (state_we) begin
      last_q <= b_d;
      acc_q  <= s_d;
    end
  end

  logic signed [BW-1:0] b_q;
  logic signed [BW:0]   d_q;
  logic signed [SW-1:0] s_q;
  logic                 p_found_q, p_mode_q;

  always_ff @(posedge clk_i) begin
    if (rdy[PIdx]) begin
      b_q       <= b_d;
      d_q       <= d_d;
      s_q       <= s_d;
      p_found_q <= found_q[NC];
      p_mode_q  <= mode_q[NC];
    end
  end

  // multiplier stage
  logic signed [2*GW-1:0]  mp_q;
  logic signed [PW-1:0]    mi_q;
  logic signed [GW+BW:0]   md_q;
  logic                    m_found_q, m_mode_q;

  always_ff @(posedge clk_i) begin
    if (rdy[MIdx]) begin
      mp_q      <= (2*GW)'(gain_p_q) * (2*GW)'(b_q);
      mi_q      <= PW'(gain_i_q) * PW'(s_q);
      md_q      <= (GW+BW+1)'(gain_d_q) * (GW+BW+1)'(d_q);
      m_found_q <= p_found_q;
      m_mode_q  <= p_mode_q;
    end
  end

  // rounding stage: sum the terms, round Q16 to nearest
  logic signed [PW-1:0] psum;
  logic signed [SW-1:0] c_q;
  logic                 r_found_q, r_mode_q;

  assign psum = PW'(mp_q) + mi_q + PW'(md_q) + PW'(32768);

  always_ff @(posedge clk_i) begin
    if (rdy[RIdx]) begin
      c_q       <= psum[PW-1:16];
      r_found_q <= m_found_q;
      r_mode_q  <= m_mode_q;
    end
  end

  // output stage: mix, mirror for reverse, clamp, zero when no target
  logic signed [VW-1:0] lt, rt, lv, rv, lim, lv_c, rv_c;
  logic signed [bpds_pkg::VelW-1:0] lv_q, rv_q;
  logic                             o_found_q;

  always_comb begin
    lt  = VW'(cruise_q) + VW'(c_q);
    rt  = VW'(cruise_q) - VW'(c_q);
    lim = $signed(VW'(limit_q));
    lv  = r_mode_q ? -rt : lt;
    rv  = r_mode_q ? -lt : rt;
    if (lv > lim) begin
      lv_c = lim;
    end else if (lv < -lim) begin
      lv_c = -lim;
    end else begin
      lv_c = lv;
    end
    if (rv > lim) begin
      rv_c = lim;
    end else if (rv < -lim) begin
      rv_c = -lim;
    end else begin
      rv_c = rv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[OIdx]) begin
      o_found_q <= r_found_q;
      lv_q      <= r_found_q ? lv_c[bpds_pkg::VelW-1:0] : '0;
      rv_q      <= r_found_q ? rv_c[bpds_pkg::VelW-1:0] : '0;
    end
  end

  assign out_o.valid          = v_q[OIdx];
  assign out_o.out_valid      = o_found_q;
  assign out_o.left_velocity  = lv_q;
  assign out_o.right_velocity = rv_q;

`ifndef SYNTH
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_we |=> ($stable(last_q) && $stable(acc_q)))
    else $error("PID state changed without a found request");

  a_no_target_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.out_valid) |->
      (out_o.left_velocity == '0 && out_o.right_velocity == '0))
    else $error("no-target result carries non-zero velocity");

  a_left_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.out_valid) |->
      ($signed(VW'(out_o.left_velocity)) <= $signed(VW'(limit_q)) &&
       $signed(VW'(out_o.left_velocity)) >= -$signed(VW'(limit_q))))
    else $error("left velocity beyond limit");

  a_bearing_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[PIdx] |->
      ($signed(b_q) <= bpds_pkg::BearingBound && $signed(b_q) >= -bpds_pkg::BearingBound))
    else $error("bearing outside +/-90 degrees");
`endif

endmodule

### dv/bearing_pid_differential_steer_tb.sv
// Testbench for bearing_pid_differential_steer: a table of directed detections and
// random detections under several stall patterns.
// Depends on bpds_pkg, bpds_in_if, bpds_out_if and the top level; checks every command.
module bearing_pid_differential_steer_tb;

  localparam int          FrameW      = 316;
  localparam longint      TanHalfFov  = 38604;
  localparam int          PipeDepth   = 13;
  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int          RandBlock   = 25;
  localparam longint      SumMax      = 64'sd2147483647;
  localparam longint      SumMin      = -64'sd2147483648;
  localparam logic        DirFwd      = 1'b0;
  localparam logic        DirRev      = 1'b1;

  localparam logic [bpds_pkg::CfgIdxW-1:0] CfgIdxSpare =
    bpds_pkg::CfgIdxW'(bpds_pkg::CfgGainD) + 1'b1;
  localparam logic [bpds_pkg::CfgIdxW-1:0] CfgIdxTop   = '1;

  localparam longint AtanDegQ16 [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  localparam int SrcIdlePct  [4] = '{0, 87, 0, 14};
  localparam int SnkStallPct [4] = '{0, 0, 87, 14};

  typedef struct packed {
    logic                          found;
    logic [bpds_pkg::BoxW-1:0]     left;
    logic [bpds_pkg::BoxW-1:0]     width;
    logic                          rev;
  } det_t;

  typedef struct packed {
    logic                              ok;
    logic signed [bpds_pkg::VelW-1:0]  left;
    logic signed [bpds_pkg::VelW-1:0]  right;
  } cmd_t;

  typedef enum logic { RowItem, RowCfg } row_kind_e;
  typedef enum logic { ChkModel, ChkTyped } row_chk_e;
  typedef enum logic [1:0] { SetRandom, SetHigh, SetLow } setting_e;

  typedef struct packed {
    row_kind_e                        kind;
    logic [bpds_pkg::CfgIdxW-1:0]     idx;
    logic [bpds_pkg::CfgDataW-1:0]    wdata;
    det_t                             det;
    row_chk_e                         chk;
    cmd_t                             want;
  } dir_row_t;

  localparam int NumDirRows = 34;

  localparam dir_row_t DirTab [NumDirRows] = '{
    // reset settings: zero gains and cruise
    '{RowItem, '0, '0, '{1'b1, 10'd158, 10'd0, DirFwd}, ChkTyped, '{1'b1, 11'sd0, 11'sd0}},
    '{RowItem, '0, '0, '{1'b0, 10'd1023, 10'd1023, DirRev}, ChkTyped, '{1'b0, 11'sd0, 11'sd0}},
    '{RowItem, '0, '0, '{1'b1, 10'd1023, 10'd1023, DirRev}, ChkTyped, '{1'b1, 11'sd0, 11'sd0}},
    // cruise extremes against the limit
    '{RowCfg, bpds_pkg::CfgCruise, 16'h03FF, '0, ChkModel, '0},
    '{RowItem, '0, '0, '{1'b1, 10'd0, 10'd0, DirFwd}, ChkTyped, '{1'b1, 11'sd600, 11'sd600}},
    '{RowItem, '0, '0, '{1'b1, 10'd0, 10'd0, DirRev}, ChkTyped, '{1'b1, -11'sd600, -11'sd600}},
    '{RowCfg, bpds_pkg::CfgLimit, 16'h03FF, '0, ChkModel, '0},
    '{RowItem, '0, '0, '{1'b1, 10'd512, 10'd0, DirFwd}, ChkTyped, '{1'b1, 11'sd1023, 11'sd1023}},
    '{RowCfg, bpds_pkg::CfgCruise, 16'h0400, '0, ChkModel, '0},
    '{RowItem, '0, '0, '{1'b1, 10'd0, 10'd1, DirFwd}, ChkTyped,
      '{1'b1, -11'sd1023, -11'sd1023}},
    '{RowItem, '0, '0, '{1'b1, 10'd300, 10'd600, DirRev}, ChkTyped,
      '{1'b1, 11'sd1023, 11'sd1023}},
    '{RowCfg, bpds_pkg::CfgLimit, 16'h0000, '0, ChkModel, '0},
    '{RowItem, '0, '0, '{1'b1, 10'd700, 10'd9, DirRev}, ChkTyped, '{1'b1, 11'sd0, 11'sd0}},
    '{RowItem, '0, '0, '{1'b0, 10'd0, 10'd0, DirFwd}, ChkTyped, '{1'b0, 11'sd0, 11'sd0}},
    // gain extremes; a centred box gives no steering
    '{RowCfg, bpds_pkg::CfgLimit, 16'h03FF, '0, ChkModel, '0},
    '{RowCfg, bpds_pkg::CfgCruise, 16'h0000, '0, ChkModel, '0},
    '{RowCfg, bpds_pkg::CfgGainP, 16'h7FFF, '0, ChkModel, '0},
    '{RowItem, '0, '0, '{1'b1, 10'd100, 10'd117, DirFwd}, ChkTyped, '{1'b1, 11'sd0, 11'sd0}},
    '{RowItem, '0, '0, '{1'b1, 10'd1023, 10'd1023, DirFwd}, ChkModel, '0},
    '{RowItem, '0, '0, '{1'b1, 10'd0, 10'd0, DirRev}, ChkModel, '0},
    '{RowCfg, bpds_pkg::CfgGainP, 16'h8000, '0, ChkModel, '0},
    '{RowItem, '0, '0, '{1'b1, 10'd157, 10'd1, DirFwd}, ChkModel, '0},
    '{RowCfg, bpds_pkg::CfgGainP, 16'h0100, '0, ChkModel, '0},
    '{RowCfg, bpds_pkg::CfgGainI, 16'h8000, '0, ChkModel, '0},
    '{RowCfg, bpds_pkg::CfgGainD, 16'h7FFF, '0, ChkModel, '0},
    '{RowItem, '0, '0, '{1'b1, 10'd159, 10'd1, DirRev}, ChkModel, '0},
    '{RowItem, '0, '0, '{1'b1, 10'd0, 10'd1023, DirFwd}, ChkModel, '0},
    '{RowCfg, bpds_pkg::CfgGainI, 16'h7FFF, '0, ChkModel, '0},
    '{RowCfg, bpds_pkg::CfgGainD, 16'h8000, '0, ChkModel, '0},
    '{RowItem, '0, '0, '{1'b1, 10'd0, 10'd0, DirFwd}, ChkModel, '0},
    '{RowItem, '0, '0, '{1'b1, 10'd1023, 10'd1023, DirRev}, ChkModel, '0},
    // writes to unmapped indexes must leave every register alone
    '{RowCfg, CfgIdxSpare, 16'hFFFF, '0, ChkModel, '0},
    '{RowCfg, CfgIdxTop, 16'hFFFF, '0, ChkModel, '0},
    '{RowItem, '0, '0, '{1'b1, 10'd400, 10'd50, DirFwd}, ChkModel, '0}
  };

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [bpds_pkg::CfgIdxW-1:0]    cfg_idx;
  logic [bpds_pkg::CfgDataW-1:0]   cfg_wdata;

  // mirror of the block's registers and PID state
  logic signed [bpds_pkg::CruiseW-1:0]   cruise_cfg;
  logic        [bpds_pkg::LimitW-1:0]    limit_cfg;
  logic signed [bpds_pkg::GainW-1:0]     gain_p_cfg;
  logic signed [bpds_pkg::GainW-1:0]     gain_i_cfg;
  logic signed [bpds_pkg::GainW-1:0]     gain_d_cfg;
  logic signed [bpds_pkg::BearingW-1:0]  last_bearing;
  logic signed [bpds_pkg::SumW-1:0]      bearing_sum;

  cmd_t         cmds_due[$];
  int           n_mismatch    = 0;
  int           src_idle_pct  = 0;
  int           snk_stall_pct = 0;
  int unsigned  cycles_run    = 0;

  bpds_in_if  det_if ();
  bpds_out_if cmd_if ();

  bearing_pid_differential_steer #(
    .FrameWidth (FrameW)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (det_if),
    .out_o       (cmd_if)
  );

  always #1 clk = ~clk;

  // Q8.8 degrees from a pixel offset, by vectoring CORDIC on |off|
  function automatic logic signed [bpds_pkg::BearingW-1:0] bearing_from_offset(
    input longint off
  );
    longint                               mag_in, x, y, z, nx;
    logic signed [bpds_pkg::BearingW-1:0] mag;
    int                                   i;
    mag_in = (off < 0) ? -off : off;
    if (mag_in == 0) return '0;
    x = longint'(FrameW) * 65536;
    y = 2 * mag_in * TanHalfFov;
    z = 0;
    for (i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + AtanDegQ16[i];
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - AtanDegQ16[i];
      end
      x = nx;
    end
    if (z < 0) z = 0;
    mag = bpds_pkg::BearingW'((z + 128) >>> 8);
    return (off < 0) ? -mag : mag;
  endfunction

  // advance the PID state by one detection and give the wheel command it yields
  function automatic cmd_t next_wheel_cmd(input det_t det);
    cmd_t   cmd;
    longint off, b, d, s, p, c, lv, rv, lim;
    if (!det.found) return '0;
    off = longint'(det.left) + longint'(det.width) / 2 - FrameW / 2;
    b   = bearing_from_offset(off);
    d   = b - last_bearing;
    s   = bearing_sum + b;
    if (s > SumMax) s = SumMax;
    if (s < SumMin) s = SumMin;
    bearing_sum  = bpds_pkg::SumW'(s);
    p = longint'(gain_p_cfg) * b + longint'(gain_i_cfg) * s + longint'(gain_d_cfg) * d;
    c = (p + 32768) >>> 16;
    last_bearing = bpds_pkg::BearingW'(b);
    if (det.rev) begin
      lv = -(cruise_cfg - c);
      rv = -(cruise_cfg + c);
    end else begin
      lv = cruise_cfg + c;
      rv = cruise_cfg - c;
    end
    lim = longint'(limit_cfg);
    if (lv > lim) lv = lim;
    if (lv < -lim) lv = -lim;
    if (rv > lim) rv = lim;
    if (rv < -lim) rv = -lim;
    cmd.ok    = 1'b1;
    cmd.left  = bpds_pkg::VelW'(lv);
    cmd.right = bpds_pkg::VelW'(rv);
    return cmd;
  endfunction

  function automatic logic [bpds_pkg::CfgDataW-1:0] pick_gain();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return bpds_pkg::CfgDataW'($urandom);
      default: return bpds_pkg::CfgDataW'(int'($urandom_range(1536)) - 768);
    endcase
  endfunction

  function automatic logic [bpds_pkg::CfgDataW-1:0] pick_cruise();
    case ($urandom_range(5))
      0:       return 16'h03FF;
      1:       return 16'h0400;
      2:       return bpds_pkg::CfgDataW'($urandom_range(2047));
      default: return bpds_pkg::CfgDataW'(int'($urandom_range(1200)) - 600);
    endcase
  endfunction

  function automatic logic [bpds_pkg::CfgDataW-1:0] pick_limit();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'h03FF;
      2:       return bpds_pkg::CfgDataW'($urandom_range(1023));
      default: return bpds_pkg::CfgDataW'($urandom_range(600, 100));
    endcase
  endfunction

  function automatic det_t rand_detection();
    det_t det;
    det.found = ($urandom_range(9) != 0);
    det.left  = ($urandom_range(1) != 0) ? bpds_pkg::BoxW'($urandom_range(FrameW - 1))
                                         : bpds_pkg::BoxW'($urandom);
    det.width = ($urandom_range(1) != 0) ? bpds_pkg::BoxW'($urandom_range(120))
                                         : bpds_pkg::BoxW'($urandom);
    det.rev   = 1'($urandom_range(1));
    return det;
  endfunction

  task automatic report_mismatch(input string what);
    n_mismatch++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_detection(input det_t det, input bit typed, input cmd_t typed_cmd);
    cmd_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      det_if.valid = 1'b0;
      @(negedge clk);
    end
    det_if.valid        = 1'b1;
    det_if.target_found = det.found;
    det_if.box_left     = det.left;
    det_if.box_width    = det.width;
    det_if.mode         = det.rev;
    do @(posedge clk); while (!det_if.ready);
    predicted = next_wheel_cmd(det);
    cmds_due.push_back(typed ? typed_cmd : predicted);
    @(negedge clk);
  endtask

  task automatic drain_cmds();
    det_if.valid = 1'b0;
    while (cmds_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [bpds_pkg::CfgIdxW-1:0] idx,
                           input logic [bpds_pkg::CfgDataW-1:0] data);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      bpds_pkg::CfgCruise: cruise_cfg = data[bpds_pkg::CruiseW-1:0];
      bpds_pkg::CfgLimit:  limit_cfg  = data[bpds_pkg::LimitW-1:0];
      bpds_pkg::CfgGainP:  gain_p_cfg = data[bpds_pkg::GainW-1:0];
      bpds_pkg::CfgGainI:  gain_i_cfg = data[bpds_pkg::GainW-1:0];
      bpds_pkg::CfgGainD:  gain_d_cfg = data[bpds_pkg::GainW-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_setting(input setting_e flav);
    drain_cmds();
    case (flav)
      SetHigh: begin
        write_reg(bpds_pkg::CfgCruise, 16'h03FF);
        write_reg(bpds_pkg::CfgLimit, 16'h03FF);
        write_reg(bpds_pkg::CfgGainP, 16'h7FFF);
        write_reg(bpds_pkg::CfgGainI, 16'h7FFF);
        write_reg(bpds_pkg::CfgGainD, 16'h7FFF);
      end
      SetLow: begin
        write_reg(bpds_pkg::CfgCruise, 16'h0400);
        write_reg(bpds_pkg::CfgLimit, 16'h0000);
        write_reg(bpds_pkg::CfgGainP, 16'h8000);
        write_reg(bpds_pkg::CfgGainI, 16'h8000);
        write_reg(bpds_pkg::CfgGainD, 16'h8000);
      end
      default: begin
        write_reg(bpds_pkg::CfgCruise, pick_cruise());
        write_reg(bpds_pkg::CfgLimit, pick_limit());
        write_reg(bpds_pkg::CfgGainP, pick_gain());
        write_reg(bpds_pkg::CfgGainI, pick_gain());
        write_reg(bpds_pkg::CfgGainD, pick_gain());
      end
    endcase
  endtask

  always @(posedge clk) begin : check_cmds
    cmd_t want;
    if (rst_n && cmd_if.valid && cmd_if.ready) begin
      if (cmds_due.size() == 0) begin
        report_mismatch($sformatf("command with none due: valid %0b left %0d right %0d",
                                  cmd_if.out_valid, cmd_if.left_velocity,
                                  cmd_if.right_velocity));
      end else begin
        want = cmds_due.pop_front();
        if (cmd_if.out_valid !== want.ok)
          report_mismatch($sformatf("out_valid %0b, want %0b", cmd_if.out_valid, want.ok));
        if (cmd_if.left_velocity !== want.left)
          report_mismatch($sformatf("left_velocity %0d, want %0d",
                                    cmd_if.left_velocity, want.left));
        if (cmd_if.right_velocity !== want.right)
          report_mismatch($sformatf("right_velocity %0d, want %0d",
                                    cmd_if.right_velocity, want.right));
      end
    end
  end

  initial begin
    cmd_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      cmd_if.ready = ($urandom_range(99) >= snk_stall_pct);
    end
  end

  initial begin
    while (cycles_run < CycleLimit) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int       k, ph, blk;
    setting_e flav;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = '0;
    cfg_wdata           = '0;
    det_if.valid        = 1'b0;
    det_if.target_found = 1'b0;
    det_if.box_left     = '0;
    det_if.box_width    = '0;
    det_if.mode         = DirFwd;
    cruise_cfg          = '0;
    limit_cfg           = bpds_pkg::LimitReset;
    gain_p_cfg          = '0;
    gain_i_cfg          = '0;
    gain_d_cfg          = '0;
    last_bearing        = '0;
    bearing_sum         = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (k = 0; k < NumDirRows; k++) begin
      if (DirTab[k].kind == RowCfg) begin
        drain_cmds();
        write_reg(DirTab[k].idx, DirTab[k].wdata);
      end else begin
        send_detection(DirTab[k].det, DirTab[k].chk == ChkTyped, DirTab[k].want);
      end
    end

    for (ph = 0; ph < 4; ph++) begin
      src_idle_pct  = SrcIdlePct[ph];
      snk_stall_pct = SnkStallPct[ph];
      for (blk = 0; blk < 4; blk++) begin
        if (blk == 0 && ph == 1) flav = SetHigh;
        else if (blk == 0 && ph == 2) flav = SetLow;
        else flav = SetRandom;
        apply_setting(flav);
        repeat (RandBlock) send_detection(rand_detection(), 1'b0, '0);
      end
    end

    drain_cmds();
    repeat (4 * PipeDepth) @(posedge clk);
    @(negedge clk);
    if (n_mismatch == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/bpds_pkg.sv
rtl/bpds_in_if.sv
rtl/bpds_out_if.sv
rtl/bearing_pid_differential_steer.sv
dv/bearing_pid_differential_steer_tb.sv
